[rtl/core/drf_pkg.sv]
// ----------------------------------------------------------------------------
// drf_pkg: shared types and constants of the disparity reprojection filter
// Register indexes, divider widths, the per-stage record of the division
// chain and its step and saturation functions.
// ----------------------------------------------------------------------------
package drf_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_X_OFFSET        = 3'd0;
  localparam logic [2:0] REG_Y_OFFSET        = 3'd1;
  localparam logic [2:0] REG_FOCAL_LENGTH    = 3'd2;
  localparam logic [2:0] REG_INV_BASELINE    = 3'd3;
  localparam logic [2:0] REG_DISP_LO         = 3'd4;
  localparam logic [2:0] REG_DISP_HI         = 3'd5;
  localparam logic [2:0] REG_MAX_DEPTH       = 3'd6;
  localparam logic [2:0] REG_DARK_LEVEL      = 3'd7;

  // |w| < 2^33, |numerator| * 2^24 < 2^48 ; quotient bits computed
  localparam int DEN_W = 33;
  localparam int NUM_W = 48;
  localparam int REM_W = DEN_W + 1;

  // restoring division, one quotient bit per cell per lane
  typedef struct packed {
    logic [NUM_W-1:0] quo;   // dividend bits shifting out, quotient bits in
    logic [REM_W-1:0] rem;
    logic             neg;   // result sign
  } div_lane_t;

  typedef struct packed {
    logic             valid;
    logic [DEN_W-1:0] den;
    div_lane_t        lx;
    div_lane_t        ly;
    div_lane_t        lz;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [30:0]      max_depth;
  } div_stage_t;

  // one restoring step
  function automatic div_lane_t div_step(div_lane_t a, logic [DEN_W-1:0] den);
    div_lane_t        o;
    logic [REM_W-1:0] r;
    logic [REM_W:0]   t;
    r = {a.rem[REM_W-2:0], a.quo[NUM_W-1]};
    t = {1'b0, r} - {2'b0, den};
    o.neg = a.neg;
    if (!t[REM_W]) begin
      o.rem = t[REM_W-1:0];
      o.quo = {a.quo[NUM_W-2:0], 1'b1};
    end else begin
      o.rem = r;
      o.quo = {a.quo[NUM_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // apply sign and saturate to 32 bits
  function automatic logic [31:0] sat_signed(div_lane_t a);
    logic [NUM_W:0] v;
    v = a.neg ? -{1'b0, a.quo} : {1'b0, a.quo};
    if (!a.neg && a.quo > NUM_W'(32'h7FFF_FFFF)) return 32'h7FFF_FFFF;
    if (a.neg && a.quo > NUM_W'(33'h8000_0000)) return 32'h8000_0000;
    return v[31:0];
  endfunction

endpackage

[rtl/core/drf_div_cell.sv]
// ----------------------------------------------------------------------------
// drf_div_cell: one cell of the division chain
// Retires one quotient bit of each of the three lanes and passes the record on.
// ----------------------------------------------------------------------------
module drf_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                stall,
  input  drf_pkg::div_stage_t in_stage,
  output drf_pkg::div_stage_t out_stage
);

  drf_pkg::div_stage_t stage_r;
  drf_pkg::div_stage_t stage_nxt;

  // step all lanes against the shared divisor
  always_comb begin
    stage_nxt    = in_stage;
    stage_nxt.lx = drf_pkg::div_step(in_stage.lx, in_stage.den);
    stage_nxt.ly = drf_pkg::div_step(in_stage.ly, in_stage.den);
    stage_nxt.lz = drf_pkg::div_step(in_stage.lz, in_stage.den);
  end

  // advance unless the chain is held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (!stall) begin
      stage_r <= stage_nxt;
    end
  end

  assign out_stage = stage_r;

endmodule

[rtl/core/drf_front.sv]
// ----------------------------------------------------------------------------
// drf_front: pixel screening and operand setup
// Applies the pixel tests, forms w and the three numerators and loads the
// head of the division chain.
// ----------------------------------------------------------------------------
module drf_front #(
  parameter int MAX_DIM = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                stall,
  input  logic                take,
  input  logic [11:0]         column,
  input  logic [11:0]         row,
  input  logic signed [15:0]  disparity,
  input  logic [7:0]          pixel_red,
  input  logic [7:0]          pixel_green,
  input  logic [7:0]          pixel_blue,
  input  logic signed [16:0]  x_offset,
  input  logic signed [16:0]  y_offset,
  input  logic [17:0]         focal_length,
  input  logic signed [17:0]  inv_baseline,
  input  logic [14:0]         disp_lo,
  input  logic [14:0]         disp_hi,
  input  logic [30:0]         max_depth,
  input  logic [7:0]          dark_level,
  output drf_pkg::div_stage_t out_stage
);

  localparam int NW = drf_pkg::NUM_W;
  localparam int DW = drf_pkg::DEN_W;

  // first stage: tests and products
  logic                  pass_r, pass_nxt;
  logic signed [33:0]    w_r;
  logic signed [17:0]    nx_r, ny_r;
  logic [17:0]           nz_r;
  logic [7:0]            red_r, green_r, blue_r;
  logic [30:0]           depth_r;

  always_comb begin
    pass_nxt = take;
    if ({3'b0, column} >= 15'(MAX_DIM) || {3'b0, row} >= 15'(MAX_DIM)) pass_nxt = 1'b0;
    if (disparity <= 16'sd0) pass_nxt = 1'b0;
    if (disparity < $signed({1'b0, disp_lo}) ||
        disparity > $signed({1'b0, disp_hi})) pass_nxt = 1'b0;
    if (pixel_red <= dark_level && pixel_green <= dark_level &&
        pixel_blue <= dark_level) pass_nxt = 1'b0;
    if (inv_baseline == 18'sd0) pass_nxt = 1'b0;
    // w < 0 gives Z <= 0
    if (inv_baseline < 18'sd0) pass_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r <= 1'b0;
    end else if (!stall) begin
      pass_r <= pass_nxt;
    end
  end

  // hold operands
  always_ff @(posedge clk) begin
    if (!stall) begin
      w_r     <= 34'(inv_baseline) * 34'(disparity);
      nx_r    <= 18'($signed({2'b0, column, 4'b0})) + 18'(x_offset);
      ny_r    <= 18'($signed({2'b0, row, 4'b0})) + 18'(y_offset);
      nz_r    <= focal_length;
      red_r   <= pixel_red;
      green_r <= pixel_green;
      blue_r  <= pixel_blue;
      depth_r <= max_depth;
    end
  end

  // load the division chain head: magnitudes scaled by 2^24
  logic [17:0] mx, my;
  assign mx = nx_r[17] ? 18'(-nx_r) : 18'(nx_r);
  assign my = ny_r[17] ? 18'(-ny_r) : 18'(ny_r);

  always_comb begin
    out_stage.valid     = pass_r;
    out_stage.den       = w_r[DW-1:0];
    out_stage.lx.quo    = NW'({mx, 24'b0});
    out_stage.lx.rem    = '0;
    out_stage.lx.neg    = nx_r[17];
    out_stage.ly.quo    = NW'({my, 24'b0});
    out_stage.ly.rem    = '0;
    out_stage.ly.neg    = ny_r[17];
    out_stage.lz.quo    = NW'({nz_r, 24'b0});
    out_stage.lz.rem    = '0;
    out_stage.lz.neg    = 1'b0;
    out_stage.red       = red_r;
    out_stage.green     = green_r;
    out_stage.blue      = blue_r;
    out_stage.max_depth = depth_r;
  end

endmodule

[rtl/core/disparity_reprojection_filter_core.sv]
// ----------------------------------------------------------------------------
// disparity_reprojection_filter_core: disparity pixel to 3D point
// Screens pixels and reprojects survivors through a chain of divider cells.
//
//   channel | signals                                   | direction
//   in      | in_valid/in_ready, column..pixel_blue     | pixel in
//   out     | out_valid/out_ready, point_x..out_blue    | point out
//   cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data  | register write
//
// One pixel per cycle while the chain is not held. A pixel passes through the
// screening stage, loaded when the pixel is accepted, then 48 divider cells
// (one quotient bit each) and one output register.
// Reset clears all valid flags and loads register defaults.
// A full output register with out_ready low holds the whole chain in place.
// ----------------------------------------------------------------------------
module disparity_reprojection_filter_core #(
  parameter int MAX_DIM = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [11:0]        in_column,
  input  logic [11:0]        in_row,
  input  logic signed [15:0] in_disparity,
  input  logic [7:0]         in_pixel_red,
  input  logic [7:0]         in_pixel_green,
  input  logic [7:0]         in_pixel_blue,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic [30:0]        out_point_z,
  output logic [7:0]         out_out_red,
  output logic [7:0]         out_out_green,
  output logic [7:0]         out_out_blue,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int NCELL = drf_pkg::NUM_W;

  // configuration registers
  logic signed [16:0] x_offset_r, y_offset_r;
  logic [17:0]        focal_length_r;
  logic signed [17:0] inv_baseline_r;
  logic [14:0]        disp_lo_r, disp_hi_r;
  logic [30:0]        max_depth_r;
  logic [7:0]         dark_level_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_offset_r     <= -17'sd5004;
      y_offset_r     <= -17'sd10616;
      focal_length_r <= 18'd14043;
      inv_baseline_r <= 18'sd26062;
      disp_lo_r      <= 15'd0;
      disp_hi_r      <= 15'd32767;
      max_depth_r    <= 31'h7FFF_FFFF;
      dark_level_r   <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        drf_pkg::REG_X_OFFSET:     x_offset_r     <= cfg_data[16:0];
        drf_pkg::REG_Y_OFFSET:     y_offset_r     <= cfg_data[16:0];
        drf_pkg::REG_FOCAL_LENGTH: focal_length_r <= cfg_data[17:0];
        drf_pkg::REG_INV_BASELINE: inv_baseline_r <= cfg_data[17:0];
        drf_pkg::REG_DISP_LO:      disp_lo_r      <= cfg_data[14:0];
        drf_pkg::REG_DISP_HI:      disp_hi_r      <= cfg_data[14:0];
        drf_pkg::REG_MAX_DEPTH:    max_depth_r    <= cfg_data[30:0];
        drf_pkg::REG_DARK_LEVEL:   dark_level_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // hold the chain while a result waits
  logic stall;
  assign stall    = out_valid && !out_ready;
  assign in_ready = !stall;

  drf_pkg::div_stage_t chain [NCELL+1];

  drf_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk, .rst_n, .stall,
    .take            (in_valid && in_ready),
    .column          (in_column),
    .row             (in_row),
    .disparity       (in_disparity),
    .pixel_red       (in_pixel_red),
    .pixel_green     (in_pixel_green),
    .pixel_blue      (in_pixel_blue),
    .x_offset        (x_offset_r),
    .y_offset        (y_offset_r),
    .focal_length    (focal_length_r),
    .inv_baseline    (inv_baseline_r),
    .disp_lo         (disp_lo_r),
    .disp_hi         (disp_hi_r),
    .max_depth       (max_depth_r),
    .dark_level      (dark_level_r),
    .out_stage       (chain[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    drf_div_cell u_cell (
      .clk, .rst_n, .stall,
      .in_stage  (chain[i]),
      .out_stage (chain[i+1])
    );
  end

  // finish: sign, saturate, depth test
  drf_pkg::div_stage_t last;
  logic [31:0] sx, sy, sz;
  logic        keep;
  assign last = chain[NCELL];
  assign sx   = drf_pkg::sat_signed(last.lx);
  assign sy   = drf_pkg::sat_signed(last.ly);
  assign sz   = drf_pkg::sat_signed(last.lz);
  assign keep = last.valid && !sz[31] && sz != 32'd0 && sz[30:0] < last.max_depth;

  logic out_valid_r;
  logic [31:0] px_r, py_r;
  logic [30:0] pz_r;
  logic [7:0]  r_r, g_r, b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!stall) begin
      out_valid_r <= keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      px_r <= sx;
      py_r <= sy;
      pz_r <= sz[30:0];
      r_r  <= last.red;
      g_r  <= last.green;
      b_r  <= last.blue;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_point_x   = px_r;
  assign out_point_y   = py_r;
  assign out_point_z   = pz_r;
  assign out_out_red   = r_r;
  assign out_out_green = g_r;
  assign out_out_blue  = b_r;

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: regression bench for disparity_reprojection_filter_core
// Streams pixels through the core under several register settings. A
// behavioral predictor computes each expected 3D point, and a monitor checks
// every output transaction against the oldest pending expectation. The pixel
// channel idles and the point channel stalls at random.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic [11:0]        column;
    logic [11:0]        row;
    logic signed [15:0] disparity;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } pixel_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [30:0]        z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } point_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [11:0]        in_column = '0;
  logic [11:0]        in_row = '0;
  logic signed [15:0] in_disparity = '0;
  logic [7:0]         in_pixel_red = '0;
  logic [7:0]         in_pixel_green = '0;
  logic [7:0]         in_pixel_blue = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_point_x;
  logic signed [31:0] out_point_y;
  logic [30:0]        out_point_z;
  logic [7:0]         out_out_red;
  logic [7:0]         out_out_green;
  logic [7:0]         out_out_blue;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  // predictor copy of the register file
  longint x_off, y_off, focal, inv_base, min_disp, max_disp, depth_limit, black_lvl;

  pixel_t pending_pixels[$];
  point_t expected_points[$];
  pixel_t cur_pixel;
  int     send_gap = 0;
  int     recv_gap = 0;
  bit     no_idle = 0;
  int     mismatches = 0;
  int     quiet_cycles = 0;

  disparity_reprojection_filter_core dut (.*);

  always #6 clk = ~clk;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      drf_pkg::REG_X_OFFSET:     x_off = longint'($signed(v[16:0]));
      drf_pkg::REG_Y_OFFSET:     y_off = longint'($signed(v[16:0]));
      drf_pkg::REG_FOCAL_LENGTH: focal = longint'(v[17:0]);
      drf_pkg::REG_INV_BASELINE: inv_base = longint'($signed(v[17:0]));
      drf_pkg::REG_DISP_LO:      min_disp = longint'(v[14:0]);
      drf_pkg::REG_DISP_HI:      max_disp = longint'(v[14:0]);
      drf_pkg::REG_MAX_DEPTH:    depth_limit = longint'(v[30:0]);
      drf_pkg::REG_DARK_LEVEL:   black_lvl = longint'(v[7:0]);
      default: ;
    endcase
  endfunction

  // screen one pixel and queue its point if it survives
  function automatic void predict_point(pixel_t p);
    longint d, w, x, y, z;
    point_t pt;
    d = longint'(p.disparity);
    if (p.column >= 4096 || p.row >= 4096) return;
    if (d <= 0 || d < min_disp || d > max_disp) return;
    if (p.red <= black_lvl && p.green <= black_lvl && p.blue <= black_lvl) return;
    w = inv_base * d;
    if (w == 0) return;
    x = sat32(((16 * longint'(p.column) + x_off) * (64'sd1 << 24)) / w);
    y = sat32(((16 * longint'(p.row) + y_off) * (64'sd1 << 24)) / w);
    z = sat32((focal * (64'sd1 << 24)) / w);
    if (z <= 0 || z >= depth_limit) return;
    pt.x = x[31:0];
    pt.y = y[31:0];
    pt.z = z[30:0];
    pt.red = p.red;
    pt.green = p.green;
    pt.blue = p.blue;
    expected_points.push_back(pt);
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 12);
  endfunction

  // pixel driver: hold until accepted, then idle and load the next one
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_point(cur_pixel);
        send_gap = draw_gap();
      end
      if (!(in_valid && !in_ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          cur_pixel = pending_pixels.pop_front();
          in_column <= cur_pixel.column;
          in_row <= cur_pixel.row;
          in_disparity <= cur_pixel.disparity;
          in_pixel_red <= cur_pixel.red;
          in_pixel_green <= cur_pixel.green;
          in_pixel_blue <= cur_pixel.blue;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // point monitor: compare each output transaction, stall at random
  always @(posedge clk) begin
    point_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected point: exp none, got x=%0d y=%0d z=%0d", out_point_x,
                     out_point_y, out_point_z);
        end else begin
          e = expected_points.pop_front();
          if (out_point_x !== e.x || out_point_y !== e.y || out_point_z !== e.z ||
              out_out_red !== e.red || out_out_green !== e.green ||
              out_out_blue !== e.blue) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                       e.x, e.y, e.z, e.red, e.green, e.blue, out_point_x, out_point_y,
                       out_point_z, out_out_red, out_out_green, out_out_blue);
          end
        end
        recv_gap = draw_gap();
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 20000) begin
      $display("disparity_reprojection_filter_core regression: fail");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, v);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(longint xo, longint yo, longint f, longint ib, longint mn,
                           longint mx, longint md, longint bk);
    write_reg(drf_pkg::REG_X_OFFSET, 32'(xo));
    write_reg(drf_pkg::REG_Y_OFFSET, 32'(yo));
    write_reg(drf_pkg::REG_FOCAL_LENGTH, 32'(f));
    write_reg(drf_pkg::REG_INV_BASELINE, 32'(ib));
    write_reg(drf_pkg::REG_DISP_LO, 32'(mn));
    write_reg(drf_pkg::REG_DISP_HI, 32'(mx));
    write_reg(drf_pkg::REG_MAX_DEPTH, 32'(md));
    write_reg(drf_pkg::REG_DARK_LEVEL, 32'(bk));
  endtask

  task automatic add_pixel(int c, int r, int d, int rd, int gr, int bl);
    pixel_t p;
    p.column = 12'(c);
    p.row = 12'(r);
    p.disparity = 16'(d);
    p.red = 8'(rd);
    p.green = 8'(gr);
    p.blue = 8'(bl);
    pending_pixels.push_back(p);
  endtask

  // mostly valid disparities with random content, some noise
  task automatic add_random_pixels(int n);
    int d;
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: d = $signed(16'($urandom()));
        1: d = $urandom_range(0, 3) - 1;
        2: d = $urandom_range(1, 64);
        default: d = $urandom_range(1, 32767);
      endcase
      add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095), d,
                $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    end
  endtask

  // drain everything, then let the pipeline settle
  task automatic wait_idle();
    while (pending_pixels.size() > 0 || in_valid || expected_points.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    x_off = -5004; y_off = -10616; focal = 14043; inv_base = 26062;
    min_disp = 0; max_disp = 32767; depth_limit = 2147483647; black_lvl = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes under reset settings
    add_pixel(0, 0, 1, 255, 255, 255);
    add_pixel(4095, 4095, 32767, 1, 0, 0);
    add_pixel(4095, 0, 0, 10, 10, 10);
    add_pixel(0, 4095, -1, 10, 10, 10);
    add_pixel(100, 200, -32768, 10, 10, 10);
    add_pixel(300, 400, 16, 0, 0, 0);
    add_pixel(300, 400, 16, 0, 0, 1);
    add_pixel(2048, 2048, 255, 0, 255, 0);
    wait_idle();

    // saturating X and Y with a small depth
    write_all(65535, -65536, 1, 1, 0, 32767, 2147483647, 0);
    add_pixel(4095, 0, 1, 9, 9, 9);
    add_pixel(0, 4095, 1, 9, 9, 9);
    add_pixel(4095, 4095, 2, 9, 9, 9);
    wait_idle();

    // saturated depth, zero baseline, negative baseline
    write_all(0, 0, 262143, 1, 0, 32767, 2147483647, 0);
    add_pixel(10, 10, 1, 5, 5, 5);
    wait_idle();
    write_reg(drf_pkg::REG_INV_BASELINE, 32'(0));
    add_pixel(10, 10, 100, 5, 5, 5);
    wait_idle();
    write_reg(drf_pkg::REG_INV_BASELINE, 32'(-131072));
    add_pixel(10, 10, 100, 5, 5, 5);
    wait_idle();

    // inverted range, zero depth limit, top black threshold, range edges
    write_all(-5004, -10616, 14043, 26062, 500, 400, 2147483647, 0);
    add_pixel(10, 10, 450, 5, 5, 5);
    wait_idle();
    write_all(-5004, -10616, 14043, 26062, 400, 500, 0, 255);
    add_pixel(10, 10, 450, 255, 255, 255);
    wait_idle();
    write_all(-5004, -10616, 14043, 26062, 400, 500, 2147483647, 254);
    add_pixel(10, 10, 399, 255, 0, 0);
    add_pixel(10, 10, 400, 255, 0, 0);
    add_pixel(10, 10, 500, 0, 255, 0);
    add_pixel(10, 10, 501, 0, 0, 255);
    add_pixel(10, 10, 450, 254, 254, 254);
    wait_idle();

    // random phases with varied settings and idling
    for (int ph = 0; ph < 8; ph++) begin
      no_idle = (ph % 3 == 1);
      if (ph == 7)
        write_all(-5004, -10616, 14043, 26062, 0, 32767, 2147483647, 0);
      else begin
        write_reg(drf_pkg::REG_X_OFFSET, $urandom());
        write_reg(drf_pkg::REG_Y_OFFSET, $urandom());
        write_reg(drf_pkg::REG_FOCAL_LENGTH, $urandom_range(1, 262143));
        write_reg(drf_pkg::REG_INV_BASELINE, ($urandom_range(0, 7) == 0) ? $urandom()
                                             : $urandom_range(1, 131071));
        write_reg(drf_pkg::REG_DISP_LO, $urandom_range(0, 300));
        write_reg(drf_pkg::REG_DISP_HI, $urandom_range(1000, 32767));
        write_reg(drf_pkg::REG_MAX_DEPTH,
                  ($urandom_range(0, 1) == 0) ? 32'h7FFF_FFFF : $urandom());
        write_reg(drf_pkg::REG_DARK_LEVEL, $urandom_range(0, 60));
      end
      add_random_pixels(125);
      wait_idle();
    end

    if (mismatches == 0)
      $display("disparity_reprojection_filter_core regression: pass");
    else
      $display("disparity_reprojection_filter_core regression: fail");
    $finish;
  end

endmodule
